// ----- rtl/core/ssf_pkg.sv -----
`timescale 1ns / 1ps
package ssf_pkg;

	typedef enum logic [3:0] {
		ST_INIT   = 4'd0,
		ST_READY  = 4'd1,
		ST_START  = 4'd2,
		ST_SEARCH = 4'd3,
		ST_ATTACK = 4'd4,
		ST_BOOST  = 4'd5,
		ST_ESCAPE = 4'd6,
		ST_END    = 4'd7,
		ST_TEST   = 4'd8
	} state_t;

	typedef enum logic [2:0] {
		MV_NONE   = 3'd0,
		MV_FWD    = 3'd1,
		MV_BACK   = 3'd2,
		MV_LEFT   = 3'd3,
		MV_RIGHT  = 3'd4,
		MV_WHEELS = 3'd5,
		MV_STOP   = 3'd6
	} motion_t;

	localparam logic [2:0] CFG_SIGHT_RANGE  = 3'd0;
	localparam logic [2:0] CFG_CLOSE_RANGE  = 3'd1;
	localparam logic [2:0] CFG_BLACK_LIMIT  = 3'd2;
	localparam logic [2:0] CFG_BOOST_LIMIT  = 3'd3;
	localparam logic [2:0] CFG_ESCAPE_LIMIT = 3'd4;
	localparam logic [2:0] CFG_CMD_START    = 3'd5;
	localparam logic [2:0] CFG_TEST_MODE    = 3'd6;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam int FLAG_FRONT = 0;
	localparam int FLAG_NEAR  = 1;
	localparam int FLAG_FL    = 2;
	localparam int FLAG_FR    = 3;
	localparam int FLAG_LEFT  = 4;
	localparam int FLAG_RIGHT = 5;

	localparam logic [7:0] SPD_CURVE_SLOW = 8'd230;
	localparam logic [7:0] SPD_FULL       = 8'd255;
	localparam logic [7:0] SPD_SEARCH     = 8'd210;
	localparam logic [7:0] SPD_ESCAPE     = 8'd200;

	localparam logic [12:0] HOLD_RUN_DELAY = 13'd4900;
	localparam logic [12:0] HOLD_BACK      = 13'd300;
	localparam logic [12:0] HOLD_TURN      = 13'd100;
	localparam logic [12:0] HOLD_TEST      = 13'd100;
	localparam logic [12:0] HOLD_END       = 13'd1000;

	localparam logic [11:0] RST_SIGHT_RANGE  = 12'd40;
	localparam logic [11:0] RST_CLOSE_RANGE  = 12'd15;
	localparam logic [11:0] RST_BLACK_LIMIT  = 12'd2000;
	localparam logic [15:0] RST_BOOST_LIMIT  = 16'd100;
	localparam logic [15:0] RST_ESCAPE_LIMIT = 16'd20;

	typedef struct packed {
		logic [11:0] sight_range;
		logic [11:0] close_range;
		logic [11:0] black_limit;
		logic [15:0] boost_limit;
		logic [15:0] escape_limit;
		logic        cmd_start;
		logic        test_mode;
	} cfg_t;

	typedef struct packed {
		logic [11:0] range_front_right;
		logic [11:0] range_front_left;
		logic [11:0] range_left;
		logic [11:0] range_right;
		logic [11:0] floor_a;
		logic [11:0] floor_b;
		logic        run_command;
		logic        stop_event;
	} item_t;

	typedef struct packed {
		logic [2:0]  motion;
		logic [7:0]  speed;
		logic [7:0]  left_speed;
		logic [7:0]  right_speed;
		logic        boost_on;
		logic [12:0] hold_ms;
		logic [3:0]  fsm_state;
		logic        starter_enable;
		logic        finished;
		logic        last;
	} result_t;

	typedef struct packed {
		result_t first;
		result_t second;
		logic    two;
	} result_pair_t;

endpackage

// ----- rtl/core/ssf_if.sv -----
`timescale 1ns / 1ps
interface ssf_in_if;
	import ssf_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ssf_out_if;
	import ssf_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/core/ssf_step.sv -----
`timescale 1ns / 1ps
module ssf_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ssf_pkg::cfg_t        cfg,
	input  logic                 advance,
	input  ssf_pkg::item_t       item,
	output ssf_pkg::result_pair_t res
);
	import ssf_pkg::*;

	state_t      state_q;
	logic [15:0] tick_q;
	logic [5:0]  flags_q;
	logic        boost_q;
	logic        starter_q;

	logic [12:0] front_sum;
	logic [5:0]  f;
	logic        line;
	state_t      st_in;
	state_t      st_ov;
	state_t      st_next;
	logic [15:0] tick_inc;
	logic [15:0] tick_next;
	logic        boost_next;
	logic        starter_next;
	result_t     r0;
	result_t     r1;
	logic        two;

	// enemy flags
	always_comb begin
		front_sum = {1'b0, item.range_front_right} + {1'b0, item.range_front_left};
		f = flags_q;
		if (front_sum < {cfg.sight_range, 1'b0}) begin
			f[FLAG_FRONT] = 1'b1;
			f[FLAG_NEAR]  = front_sum < {cfg.close_range, 1'b0};
		end else begin
			f[FLAG_FRONT] = 1'b0;
			f[FLAG_NEAR]  = 1'b0;
			if (item.range_front_right < cfg.sight_range) begin
				f[FLAG_FR] = 1'b1;
			end else if (item.range_front_left < cfg.sight_range) begin
				f[FLAG_FL] = 1'b1;
			end else begin
				f[FLAG_FL] = 1'b0;
				f[FLAG_FR] = 1'b0;
			end
		end
		f[FLAG_LEFT]  = item.range_left < cfg.sight_range;
		f[FLAG_RIGHT] = item.range_right < cfg.sight_range;
	end

	// overrides
	always_comb begin
		st_in = (state_q > ST_TEST) ? ST_INIT : state_q;
		line  = (item.floor_a > cfg.black_limit) || (item.floor_b > cfg.black_limit);
		st_ov = st_in;
		priority if (item.stop_event && !cfg.cmd_start && starter_q && st_in != ST_TEST) begin
			st_ov = ST_END;
		end else if (line && st_in >= ST_SEARCH && st_in <= ST_ESCAPE) begin
			st_ov = ST_ESCAPE;
		end else begin
			st_ov = st_in;
		end
	end

	assign tick_inc = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;

	// next state
	always_comb begin
		st_next = st_ov;
		unique case (st_ov)
			ST_INIT:   st_next = cfg.test_mode ? ST_TEST : ST_READY;
			ST_READY: begin
				if (!cfg.cmd_start || item.run_command) st_next = ST_START;
			end
			ST_START: begin
				st_next = (f[FLAG_LEFT] || f[FLAG_RIGHT]) ? ST_BOOST : ST_SEARCH;
			end
			ST_SEARCH: begin
				if (f[FLAG_FRONT]) st_next = ST_ATTACK;
			end
			ST_ATTACK: begin
				if (f[FLAG_NEAR]) st_next = ST_BOOST;
				else if (!f[FLAG_FRONT]) st_next = ST_SEARCH;
			end
			ST_BOOST: begin
				if (!f[FLAG_NEAR]) begin
					if (!f[FLAG_FL] && !f[FLAG_FR]) st_next = ST_ATTACK;
				end else if (tick_inc > cfg.boost_limit) begin
					st_next = ST_ESCAPE;
				end
			end
			ST_ESCAPE: begin
				if (!(tick_q < cfg.escape_limit && !f[FLAG_FRONT])) begin
					st_next = f[FLAG_FRONT] ? ST_ATTACK : ST_SEARCH;
				end
			end
			ST_END:    st_next = ST_END;
			ST_TEST:   st_next = ST_TEST;
			default:   st_next = ST_READY;
		endcase
	end

	// commands and state updates
	always_comb begin
		r0           = '0;
		r1           = '0;
		two          = 1'b0;
		tick_next    = tick_q;
		boost_next   = boost_q;
		starter_next = starter_q;
		r0.motion    = MV_NONE;
		r1.motion    = MV_NONE;
		unique case (st_ov)
			ST_INIT: begin
				if (cfg.test_mode) r0.hold_ms = HOLD_TEST;
				else if (!cfg.cmd_start) starter_next = 1'b1;
			end
			ST_READY: begin
				if (cfg.cmd_start && item.run_command) r0.hold_ms = HOLD_RUN_DELAY;
			end
			ST_START: begin
				r0.motion  = MV_BACK;
				r0.hold_ms = HOLD_BACK;
				if (f[FLAG_LEFT] || f[FLAG_RIGHT]) begin
					two        = 1'b1;
					r1.motion  = f[FLAG_LEFT] ? MV_LEFT : MV_RIGHT;
					r1.hold_ms = HOLD_TURN;
				end
			end
			ST_SEARCH: begin
				r0.motion = MV_RIGHT;
				r0.speed  = SPD_SEARCH;
			end
			ST_ATTACK: r0.motion = MV_FWD;
			ST_BOOST: begin
				boost_next = 1'b1;
				tick_next  = tick_inc;
				if (!f[FLAG_NEAR]) begin
					if (f[FLAG_FL]) begin
						r0.motion      = MV_WHEELS;
						r0.left_speed  = SPD_CURVE_SLOW;
						r0.right_speed = SPD_FULL;
					end else if (f[FLAG_FR]) begin
						r0.motion      = MV_WHEELS;
						r0.left_speed  = SPD_FULL;
						r0.right_speed = SPD_CURVE_SLOW;
					end else begin
						boost_next = 1'b0;
						tick_next  = '0;
					end
				end else if (tick_inc > cfg.boost_limit) begin
					boost_next = 1'b0;
					tick_next  = '0;
				end
			end
			ST_ESCAPE: begin
				if (tick_q < cfg.escape_limit && !f[FLAG_FRONT]) begin
					tick_next = tick_q + 16'd1;
					r0.motion = MV_BACK;
					r0.speed  = SPD_ESCAPE;
				end else begin
					tick_next = '0;
				end
			end
			ST_END: begin
				starter_next = 1'b0;
				boost_next   = 1'b0;
				r0.motion    = MV_STOP;
				r0.hold_ms   = HOLD_END;
				r0.finished  = 1'b1;
			end
			ST_TEST:   r0.hold_ms = HOLD_TEST;
			default:   r0.hold_ms = '0;
		endcase
		r0.boost_on       = boost_next;
		r1.boost_on       = boost_next;
		r0.fsm_state      = st_next;
		r1.fsm_state      = st_next;
		r0.starter_enable = starter_next;
		r1.starter_enable = starter_next;
		r0.last           = !two;
		r1.last           = 1'b1;
	end

	assign res.first  = r0;
	assign res.second = r1;
	assign res.two    = two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			tick_q    <= '0;
			flags_q   <= '0;
			boost_q   <= 1'b0;
			starter_q <= 1'b0;
		end else if (advance) begin
			state_q   <= st_next;
			tick_q    <= tick_next;
			flags_q   <= f;
			boost_q   <= boost_next;
			starter_q <= starter_next;
		end
	end

	a_two_only_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		two |-> (st_ov == ST_START && st_next == ST_BOOST))
		else $error("two commands outside start sequence");

	a_end_drops_starter: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && st_next == ST_END) |=> (!starter_q && !boost_q))
		else $error("end state left starter or boost on");

endmodule

// ----- rtl/core/ssf_outbuf.sv -----
`timescale 1ns / 1ps
module ssf_outbuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  ssf_pkg::result_pair_t res,
	output logic                  free,
	ssf_out_if.source             command
);
	import ssf_pkg::*;

	logic    valid_q;
	logic    two_q;
	logic    idx_q;
	result_t r0_q;
	result_t r1_q;
	logic    cur_last;
	logic    xfer;

	assign cur_last      = !two_q || idx_q;
	assign xfer          = valid_q && command.ready;
	assign free          = !valid_q || (command.ready && cur_last);
	assign command.valid = valid_q;
	assign command.data  = idx_q ? r1_q : r0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			two_q   <= 1'b0;
			idx_q   <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			two_q   <= res.two;
			idx_q   <= 1'b0;
		end else if (xfer) begin
			if (cur_last) begin
				valid_q <= 1'b0;
				idx_q   <= 1'b0;
			end else begin
				idx_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			r0_q <= res.first;
			r1_q <= res.second;
		end
	end

	a_second_needs_pair: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q |-> (two_q && valid_q))
		else $error("second command selected without a pair");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result loaded over a pending command");

endmodule

// ----- rtl/core/sumo_robot_strategy_fsm_top.sv -----
`timescale 1ns / 1ps
// path: input stage register, then output buffer register, then command transfer
// throughput: one control tick per cycle while commands are taken; a start-sequence tick
//   seeing a side enemy emits two commands in turn and holds the input until both are taken
// reset: asynchronous active low; configuration returns to defaults, state machine to init,
//   counters, enemy flags, boost and starter levels clear
module sumo_robot_strategy_fsm_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ssf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ssf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	ssf_in_if.sink                              sensor,
	ssf_out_if.source                           command
);
	import ssf_pkg::*;

	cfg_t         cfg_q;
	logic         valid_s1;
	item_t        item_s1;
	logic         free;
	logic         advance;
	result_pair_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sight_range  <= RST_SIGHT_RANGE;
			cfg_q.close_range  <= RST_CLOSE_RANGE;
			cfg_q.black_limit  <= RST_BLACK_LIMIT;
			cfg_q.boost_limit  <= RST_BOOST_LIMIT;
			cfg_q.escape_limit <= RST_ESCAPE_LIMIT;
			cfg_q.cmd_start    <= 1'b0;
			cfg_q.test_mode    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SIGHT_RANGE:  cfg_q.sight_range  <= cfg_wdata[11:0];
				CFG_CLOSE_RANGE:  cfg_q.close_range  <= cfg_wdata[11:0];
				CFG_BLACK_LIMIT:  cfg_q.black_limit  <= cfg_wdata[11:0];
				CFG_BOOST_LIMIT:  cfg_q.boost_limit  <= cfg_wdata;
				CFG_ESCAPE_LIMIT: cfg_q.escape_limit <= cfg_wdata;
				CFG_CMD_START:    cfg_q.cmd_start    <= cfg_wdata[0];
				CFG_TEST_MODE:    cfg_q.test_mode    <= cfg_wdata[0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	assign advance      = valid_s1 && free;
	assign sensor.ready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sensor.ready) begin
			valid_s1 <= sensor.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.ready && sensor.valid) item_s1 <= sensor.data;
	end

	ssf_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.advance (advance),
		.item    (item_s1),
		.res     (res)
	);

	ssf_outbuf u_outbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance),
		.res     (res),
		.free    (free),
		.command (command)
	);

endmodule

// ----- tb/tb_sumo_robot_strategy_fsm_top.sv -----
`timescale 1ns / 1ps
module tb_sumo_robot_strategy_fsm_top;
	import ssf_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANGE_MAX = 4095;

	typedef enum int {
		SCENE_CLEAR,
		SCENE_FRONT,
		SCENE_NEAR,
		SCENE_EDGE_LEFT,
		SCENE_EDGE_RIGHT,
		SCENE_NOISE
	} scene_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ssf_in_if sensor_if();
	ssf_out_if command_if();

	sumo_robot_strategy_fsm_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.sensor(sensor_if),
		.command(command_if)
	);

	// predictor copy of configuration and state
	cfg_t model_cfg;
	state_t ctrl_state;
	logic [15:0] boost_ticks;
	logic [5:0] enemy_seen;
	logic boost_lvl;
	logic starter_lvl;

	result_t expected_cmds[$];
	int mismatch_count;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_off_left;
	scene_t current_scene;
	int scene_ticks_left;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver side: random stalls, or a counted hold-off
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			command_if.ready <= 1'b0;
			hold_off_left = hold_off_left - 1;
		end else begin
			command_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("ERROR %0t: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	always @(posedge clk) begin : check_commands
		result_t got;
		result_t want;
		if (arst_n && command_if.valid && command_if.ready) begin
			got = command_if.data;
			if (expected_cmds.size() == 0) begin
				report_mismatch("command transfer with no command expected");
			end else begin
				want = expected_cmds.pop_front();
				compare_field("motion", 16'(got.motion), 16'(want.motion));
				compare_field("speed", 16'(got.speed), 16'(want.speed));
				compare_field("left_speed", 16'(got.left_speed), 16'(want.left_speed));
				compare_field("right_speed", 16'(got.right_speed), 16'(want.right_speed));
				compare_field("boost_on", 16'(got.boost_on), 16'(want.boost_on));
				compare_field("hold_ms", 16'(got.hold_ms), 16'(want.hold_ms));
				compare_field("fsm_state", 16'(got.fsm_state), 16'(want.fsm_state));
				compare_field("starter_enable", 16'(got.starter_enable),
					16'(want.starter_enable));
				compare_field("finished", 16'(got.finished), 16'(want.finished));
				compare_field("last", 16'(got.last), 16'(want.last));
			end
		end
	end

	function automatic result_t motor_cmd(input motion_t mv, input logic [7:0] spd,
		input logic [7:0] ls, input logic [7:0] rs, input logic [12:0] hold);
		result_t c;
		c = '0;
		c.motion = mv;
		c.speed = spd;
		c.left_speed = ls;
		c.right_speed = rs;
		c.hold_ms = hold;
		return c;
	endfunction

	task predict_commands(input item_t tick);
		result_t cmds [2];
		int n;
		int front_sum;
		int det;
		logic [5:0] f;
		logic line;
		state_t st;
		n = 1;
		f = enemy_seen;
		st = ctrl_state;
		det = int'(model_cfg.sight_range);
		front_sum = int'(tick.range_front_right) + int'(tick.range_front_left);

		if (front_sum < 2 * det) begin
			f[FLAG_FRONT] = 1'b1;
			f[FLAG_NEAR] = (front_sum < 2 * int'(model_cfg.close_range));
		end else begin
			f[FLAG_FRONT] = 1'b0;
			f[FLAG_NEAR] = 1'b0;
			if (tick.range_front_right < model_cfg.sight_range) begin
				f[FLAG_FR] = 1'b1;
			end else if (tick.range_front_left < model_cfg.sight_range) begin
				f[FLAG_FL] = 1'b1;
			end else begin
				f[FLAG_FL] = 1'b0;
				f[FLAG_FR] = 1'b0;
			end
		end
		f[FLAG_LEFT] = (tick.range_left < model_cfg.sight_range);
		f[FLAG_RIGHT] = (tick.range_right < model_cfg.sight_range);
		enemy_seen = f;

		line = (tick.floor_a > model_cfg.black_limit) || (tick.floor_b > model_cfg.black_limit);
		if (tick.stop_event && !model_cfg.cmd_start && starter_lvl && st != ST_TEST)
			st = ST_END;
		else if (line && st >= ST_SEARCH && st <= ST_ESCAPE)
			st = ST_ESCAPE;

		case (st)
			ST_INIT: begin
				if (model_cfg.test_mode) begin
					st = ST_TEST;
					cmds[0] = motor_cmd(MV_NONE, '0, '0, '0, HOLD_TEST);
				end else begin
					if (!model_cfg.cmd_start)
						starter_lvl = 1'b1;
					cmds[0] = motor_cmd(MV_NONE, '0, '0, '0, '0);
					st = ST_READY;
				end
			end
			ST_READY: begin
				if (!model_cfg.cmd_start) begin
					cmds[0] = motor_cmd(MV_NONE, '0, '0, '0, '0);
					st = ST_START;
				end else if (tick.run_command) begin
					cmds[0] = motor_cmd(MV_NONE, '0, '0, '0, HOLD_RUN_DELAY);
					st = ST_START;
				end else begin
					cmds[0] = motor_cmd(MV_NONE, '0, '0, '0, '0);
				end
			end
			ST_START: begin
				cmds[0] = motor_cmd(MV_BACK, '0, '0, '0, HOLD_BACK);
				if (f[FLAG_LEFT]) begin
					cmds[1] = motor_cmd(MV_LEFT, '0, '0, '0, HOLD_TURN);
					n = 2;
					st = ST_BOOST;
				end else if (f[FLAG_RIGHT]) begin
					cmds[1] = motor_cmd(MV_RIGHT, '0, '0, '0, HOLD_TURN);
					n = 2;
					st = ST_BOOST;
				end else begin
					st = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmds[0] = motor_cmd(MV_RIGHT, SPD_SEARCH, '0, '0, '0);
				if (f[FLAG_FRONT])
					st = ST_ATTACK;
			end
			ST_ATTACK: begin
				cmds[0] = motor_cmd(MV_FWD, '0, '0, '0, '0);
				if (f[FLAG_NEAR])
					st = ST_BOOST;
				else if (!f[FLAG_FRONT])
					st = ST_SEARCH;
			end
			ST_BOOST: begin
				boost_lvl = 1'b1;
				if (boost_ticks != 16'hFFFF)
					boost_ticks++;
				cmds[0] = motor_cmd(MV_NONE, '0, '0, '0, '0);
				if (!f[FLAG_NEAR]) begin
					if (f[FLAG_FL]) begin
						cmds[0] = motor_cmd(MV_WHEELS, '0, SPD_CURVE_SLOW, SPD_FULL, '0);
					end else if (f[FLAG_FR]) begin
						cmds[0] = motor_cmd(MV_WHEELS, '0, SPD_FULL, SPD_CURVE_SLOW, '0);
					end else begin
						boost_lvl = 1'b0;
						boost_ticks = '0;
						st = ST_ATTACK;
					end
				end else if (boost_ticks > model_cfg.boost_limit) begin
					boost_lvl = 1'b0;
					boost_ticks = '0;
					st = ST_ESCAPE;
				end
			end
			ST_ESCAPE: begin
				if (boost_ticks < model_cfg.escape_limit && !f[FLAG_FRONT]) begin
					boost_ticks++;
					cmds[0] = motor_cmd(MV_BACK, SPD_ESCAPE, '0, '0, '0);
				end else begin
					boost_ticks = '0;
					st = f[FLAG_FRONT] ? ST_ATTACK : ST_SEARCH;
					cmds[0] = motor_cmd(MV_NONE, '0, '0, '0, '0);
				end
			end
			ST_END: begin
				starter_lvl = 1'b0;
				boost_lvl = 1'b0;
				cmds[0] = motor_cmd(MV_STOP, '0, '0, '0, HOLD_END);
				cmds[0].finished = 1'b1;
			end
			default: begin
				cmds[0] = motor_cmd(MV_NONE, '0, '0, '0, HOLD_TEST);
			end
		endcase

		ctrl_state = st;
		for (int k = 0; k < n; k++) begin
			cmds[k].boost_on = boost_lvl;
			cmds[k].fsm_state = st;
			cmds[k].starter_enable = starter_lvl;
			cmds[k].last = (k == n - 1);
			expected_cmds.push_back(cmds[k]);
		end
	endtask

	function automatic item_t make_tick(input int fr, input int fl, input int sl, input int sr,
		input int fa, input int fb, input bit run, input bit stop);
		item_t t;
		t.range_front_right = 12'(fr);
		t.range_front_left = 12'(fl);
		t.range_left = 12'(sl);
		t.range_right = 12'(sr);
		t.floor_a = 12'(fa);
		t.floor_b = 12'(fb);
		t.run_command = run;
		t.stop_event = stop;
		return t;
	endfunction

	function automatic int pick_below(input int thr);
		return (thr > 0) ? int'($urandom_range(thr - 1, 0)) : 0;
	endfunction

	function automatic int pick_from(input int thr);
		return (thr > RANGE_MAX) ? RANGE_MAX : int'($urandom_range(RANGE_MAX, thr));
	endfunction

	// enemy scenes persist for a run of ticks so the machine gets deep into boost and escape
	function automatic item_t random_tick();
		item_t t;
		int det;
		int bd;
		int blk;
		int fr;
		int fl;
		int fa;
		int fb;
		det = int'(model_cfg.sight_range);
		bd = int'(model_cfg.close_range);
		blk = int'(model_cfg.black_limit);
		if (scene_ticks_left == 0) begin
			current_scene = scene_t'($urandom_range(5));
			scene_ticks_left = ($urandom_range(99) < 4) ? $urandom_range(250, 120)
				: $urandom_range(20, 1);
		end
		scene_ticks_left--;
		case (current_scene)
			SCENE_CLEAR: begin
				fr = pick_from(det);
				fl = pick_from(det);
			end
			SCENE_FRONT: begin
				fr = (bd < det) ? int'($urandom_range(det - 1, bd)) : pick_below(det);
				fl = (bd < det) ? int'($urandom_range(det - 1, bd)) : pick_below(det);
			end
			SCENE_NEAR: begin
				fr = pick_below(bd);
				fl = pick_below(bd);
			end
			SCENE_EDGE_LEFT: begin
				fr = RANGE_MAX;
				fl = pick_below(det);
			end
			SCENE_EDGE_RIGHT: begin
				fr = pick_below(det);
				fl = RANGE_MAX;
			end
			default: begin
				fr = $urandom_range(RANGE_MAX);
				fl = $urandom_range(RANGE_MAX);
			end
		endcase
		fa = $urandom_range(blk);
		fb = $urandom_range(blk);
		if ($urandom_range(99) < 8) begin
			if ($urandom_range(1))
				fa = pick_from(blk + 1);
			else
				fb = pick_from(blk + 1);
		end
		if (current_scene == SCENE_NOISE) begin
			fa = $urandom_range(RANGE_MAX);
			fb = $urandom_range(RANGE_MAX);
		end
		t = make_tick(fr, fl,
			($urandom_range(3) == 0) ? pick_below(det) : int'($urandom_range(RANGE_MAX)),
			($urandom_range(3) == 0) ? pick_below(det) : int'($urandom_range(RANGE_MAX)),
			fa, fb, 1'($urandom_range(1)), 1'($urandom_range(1)));
		return t;
	endfunction

	task automatic send_tick(input item_t tick);
		while ($urandom_range(99) < send_idle_pct) begin
			sensor_if.valid <= 1'b0;
			@(negedge clk);
		end
		sensor_if.valid <= 1'b1;
		sensor_if.data <= tick;
		@(posedge clk);
		while (!sensor_if.ready)
			@(posedge clk);
		predict_commands(tick);
		@(negedge clk);
	endtask

	task automatic drain_commands();
		sensor_if.valid <= 1'b0;
		while (expected_cmds.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= 16'(value);
		case (idx)
			CFG_SIGHT_RANGE: model_cfg.sight_range = 12'(value);
			CFG_CLOSE_RANGE: model_cfg.close_range = 12'(value);
			CFG_BLACK_LIMIT: model_cfg.black_limit = 12'(value);
			CFG_BOOST_LIMIT: model_cfg.boost_limit = 16'(value);
			CFG_ESCAPE_LIMIT: model_cfg.escape_limit = 16'(value);
			CFG_CMD_START: model_cfg.cmd_start = value[0];
			CFG_TEST_MODE: model_cfg.test_mode = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_settings(input int det, input int bd, input int blk,
		input int blim, input int elim);
		write_cfg(CFG_SIGHT_RANGE, det);
		write_cfg(CFG_CLOSE_RANGE, bd);
		write_cfg(CFG_BLACK_LIMIT, blk);
		write_cfg(CFG_BOOST_LIMIT, blim);
		write_cfg(CFG_ESCAPE_LIMIT, elim);
	endtask

	task automatic apply_random_settings();
		int det;
		det = $urandom_range(600, 20);
		apply_settings(det, $urandom_range(det, 0), $urandom_range(3500, 1000),
			$urandom_range(40, 0), $urandom_range(40, 0));
	endtask

	task automatic run_random_ticks(input int count);
		repeat (count) send_tick(random_tick());
		drain_commands();
	endtask

	task automatic test_startup_sequence();
		// stop and floor line are ignored before the fight starts
		send_tick(make_tick(4095, 4095, 4095, 4095, 4095, 0, 0, 1));
		drain_commands();
		write_cfg(CFG_CMD_START, 1);
		send_tick(make_tick(4095, 4095, 4095, 4095, 0, 2001, 0, 1));
		send_tick(make_tick(0, 4095, 4095, 4095, 0, 0, 0, 0));
		send_tick(make_tick(4095, 4095, 4095, 4095, 0, 0, 1, 0));
		// both sides seen: left wins, two commands
		send_tick(make_tick(4095, 4095, 10, 10, 0, 0, 0, 0));
		drain_commands();
	endtask

	task automatic test_combat_directed();
		send_tick(make_tick(0, 0, 4095, 4095, 0, 0, 0, 0));
		send_tick(make_tick(4095, 10, 4095, 4095, 0, 0, 0, 0));
		send_tick(make_tick(10, 4095, 4095, 4095, 0, 0, 0, 0));
		send_tick(make_tick(4095, 4095, 4095, 4095, 0, 0, 0, 0));
		send_tick(make_tick(30, 30, 4095, 4095, 0, 0, 1, 1));
		send_tick(make_tick(4095, 4095, 4095, 4095, 0, 0, 0, 0));
		send_tick(make_tick(4095, 4095, 0, 39, 0, 0, 0, 0));
		send_tick(make_tick(20, 20, 4095, 4095, 0, 0, 0, 0));
		send_tick(make_tick(5, 5, 4095, 4095, 0, 0, 0, 0));
		send_tick(make_tick(5, 5, 4095, 4095, 2000, 2000, 0, 0));
		send_tick(make_tick(4095, 4095, 4095, 4095, 0, 2001, 0, 0));
		send_tick(make_tick(4095, 4095, 4095, 4095, 4095, 0, 0, 0));
		send_tick(make_tick(0, 0, 4095, 4095, 0, 0, 0, 0));
		send_tick(make_tick(4095, 4095, 4095, 4095, 4095, 4095, 0, 0));
		drain_commands();
	endtask

	task automatic test_random_traffic();
		send_idle_pct = 11;
		recv_idle_pct = 48;
		run_random_ticks(250);
		apply_settings(4095, 4095, 4095, 0, 0);
		write_cfg(CFG_TEST_MODE, 1);
		run_random_ticks(200);
		send_idle_pct = 48;
		recv_idle_pct = 11;
		apply_settings(0, 0, 0, 65535, 65535);
		write_cfg(CFG_TEST_MODE, 0);
		run_random_ticks(200);
		apply_random_settings();
		run_random_ticks(200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		apply_random_settings();
		run_random_ticks(100);
		apply_settings(int'(RST_SIGHT_RANGE), int'(RST_CLOSE_RANGE), int'(RST_BLACK_LIMIT),
			int'(RST_BOOST_LIMIT), int'(RST_ESCAPE_LIMIT));
		run_random_ticks(100);
	endtask

	task automatic test_output_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(posedge clk);
		hold_off_left = 80;
		@(negedge clk);
		repeat (40) send_tick(random_tick());
		drain_commands();
	endtask

	task automatic test_boost_limit();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		apply_settings(40, 15, 4095, 3, 5);
		// enemy held near: boost runs past the limit, escapes and comes back
		repeat (12) send_tick(make_tick(0, 0, 4095, 4095, 0, 0, 0, 0));
		repeat (8) send_tick(make_tick(4095, 4095, 4095, 4095, 0, 0, 0, 0));
		drain_commands();
	endtask

	task automatic test_stop_and_end();
		item_t t;
		send_idle_pct = 11;
		recv_idle_pct = 48;
		write_cfg(CFG_CMD_START, 0);
		repeat (3) begin
			t = random_tick();
			t.stop_event = 1'b0;
			send_tick(t);
		end
		// stop wins over a floor line
		send_tick(make_tick(4095, 4095, 4095, 4095, 4095, 4095, 0, 1));
		repeat (6) send_tick(random_tick());
		drain_commands();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sensor_if.valid = 1'b0;
		sensor_if.data = '0;
		command_if.ready = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		send_idle_pct = 11;
		recv_idle_pct = 48;
		hold_off_left = 0;
		scene_ticks_left = 0;
		current_scene = SCENE_CLEAR;
		model_cfg.sight_range = RST_SIGHT_RANGE;
		model_cfg.close_range = RST_CLOSE_RANGE;
		model_cfg.black_limit = RST_BLACK_LIMIT;
		model_cfg.boost_limit = RST_BOOST_LIMIT;
		model_cfg.escape_limit = RST_ESCAPE_LIMIT;
		model_cfg.cmd_start = 1'b0;
		model_cfg.test_mode = 1'b0;
		ctrl_state = ST_INIT;
		boost_ticks = '0;
		enemy_seen = '0;
		boost_lvl = 1'b0;
		starter_lvl = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_startup_sequence();
		test_combat_directed();
		test_random_traffic();
		test_output_stall();
		test_boost_limit();
		test_stop_and_end();

		repeat (8) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/ssf_pkg.sv
rtl/core/ssf_if.sv
rtl/core/ssf_step.sv
rtl/core/ssf_outbuf.sv
rtl/core/sumo_robot_strategy_fsm_top.sv
tb/tb_sumo_robot_strategy_fsm_top.sv
